[rtl/core/fdrs_pkg.sv]
`timescale 1ns / 1ps
// Package for the FLOOK disk request scheduler: field widths, command codes
// and the structs that travel along the row of request cells. No dependencies.
package fdrs_pkg;

    localparam int TRACK_W = 12;
    localparam int ID_W    = 10;
    // Slot index width, sized for the largest supported queue depth of 256.
    localparam int SLOT_W  = 8;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_GRANT = 1'b1;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [SLOT_W-1:0] idx;
        logic [ID_W-1:0]   id;
        logic [TRACK_W-1:0] track;
    } wr_cmd_t;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [SLOT_W-1:0] idx;
    } clr_cmd_t;

    // Search token: best candidates found so far in the cells already passed.
    typedef struct packed {
        logic               vld;
        logic               bank;
        logic [TRACK_W-1:0] head;
        logic               ex_hit;
        logic [SLOT_W-1:0]  ex_idx;
        logic [ID_W-1:0]    ex_id;
        logic               up_hit;
        logic [SLOT_W-1:0]  up_idx;
        logic [ID_W-1:0]    up_id;
        logic [TRACK_W-1:0] up_track;
        logic               dn_hit;
        logic [SLOT_W-1:0]  dn_idx;
        logic [ID_W-1:0]    dn_id;
        logic [TRACK_W-1:0] dn_track;
    } token_t;

endpackage

[rtl/core/fdrs_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the disk request scheduler: valid/ready plus one command item.
// Depends on fdrs_pkg for the field widths.
interface fdrs_req_if;
    import fdrs_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [ID_W-1:0]    request_id;
    logic [TRACK_W-1:0] request_track;
    logic [TRACK_W-1:0] head_track;

    modport source (output valid, command, request_id, request_track, head_track,
                    input ready);
    modport sink   (input valid, command, request_id, request_track, head_track,
                    output ready);
endinterface

[rtl/core/fdrs_res_if.sv]
`timescale 1ns / 1ps
// Result channel of the disk request scheduler: valid/ready plus one result item.
// Depends on fdrs_pkg for the field widths.
interface fdrs_res_if;
    import fdrs_pkg::*;

    logic               valid;
    logic               ready;
    logic               granted;
    logic [ID_W-1:0]    grant_id;
    logic [TRACK_W-1:0] grant_track;
    logic               dropped;
    logic               all_empty;

    modport source (output valid, granted, grant_id, grant_track, dropped, all_empty,
                    input ready);
    modport sink   (input valid, granted, grant_id, grant_track, dropped, all_empty,
                    output ready);
endinterface

[rtl/core/flook_disk_request_scheduler.sv]
`timescale 1ns / 1ps
// FLOOK disk request scheduler: a row of QUEUE_DEPTH cells, each holding one slot
// of both banks. An add passes through the pending registers to the result register.
// A grant sends a search token down the row, one cell a cycle, and its pick passes
// through the pending registers to the result register. Both wait out any result
// stall, and the next item is accepted once the result register holds the last.
// Reset (asynchronous, active low) empties both queues and sets direction upward.
module flook_disk_request_scheduler #(
    parameter int QUEUE_DEPTH = 32
) (
    input logic        clk,
    input logic        rst_n,
    fdrs_req_if.sink   req,
    fdrs_res_if.source res
);
    import fdrs_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic               active_reg, active_next;
    logic               moving_up_reg, moving_up_next;
    logic [FILL_W-1:0]  fill0_reg, fill0_next;
    logic [FILL_W-1:0]  fill1_reg, fill1_next;
    logic [FILL_W-1:0]  act_cnt_reg, act_cnt_next;
    logic               pend_granted_reg, pend_granted_next;
    logic [ID_W-1:0]    pend_id_reg, pend_id_next;
    logic [TRACK_W-1:0] pend_track_reg, pend_track_next;
    logic               pend_dropped_reg, pend_dropped_next;
    logic               out_vld_reg, out_vld_next;
    logic               out_granted_reg, out_granted_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [TRACK_W-1:0] out_track_reg, out_track_next;
    logic               out_dropped_reg, out_dropped_next;
    logic               out_empty_reg, out_empty_next;

    logic               acc;
    logic [FILL_W-1:0]  fill_add;
    wr_cmd_t            wr;
    clr_cmd_t           clr;
    token_t             tok [QUEUE_DEPTH+1];
    token_t             launch;
    token_t             tok_last;

    assign req.ready = (state_reg == ST_IDLE);
    assign acc       = req.valid && req.ready;
    // The add queue is the bank that is not active.
    assign fill_add  = active_reg ? fill0_reg : fill1_reg;
    assign tok[0]    = launch;
    assign tok_last  = tok[QUEUE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            fdrs_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr      (wr),
                .clr     (clr),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next        = state_reg;
        active_next       = active_reg;
        moving_up_next    = moving_up_reg;
        fill0_next        = fill0_reg;
        fill1_next        = fill1_reg;
        act_cnt_next      = act_cnt_reg;
        pend_granted_next = pend_granted_reg;
        pend_id_next      = pend_id_reg;
        pend_track_next   = pend_track_reg;
        pend_dropped_next = pend_dropped_reg;
        out_vld_next      = out_vld_reg && !res.ready;
        out_granted_next  = out_granted_reg;
        out_id_next       = out_id_reg;
        out_track_next    = out_track_reg;
        out_dropped_next  = out_dropped_reg;
        out_empty_next    = out_empty_reg;
        wr                = '0;
        clr               = '0;
        launch            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (req.command == CMD_ADD)
                    begin
                        pend_granted_next = 1'b0;
                        pend_id_next      = '0;
                        pend_track_next   = '0;
                        if (fill_add >= FILL_W'(QUEUE_DEPTH))
                        begin
                            pend_dropped_next = 1'b1;
                        end
                        else
                        begin
                            pend_dropped_next = 1'b0;
                            wr.en    = 1'b1;
                            wr.bank  = ~active_reg;
                            wr.idx   = SLOT_W'(fill_add);
                            wr.id    = req.request_id;
                            wr.track = req.request_track;
                            if (active_reg)
                            begin
                                fill0_next = fill0_reg + FILL_W'(1);
                            end
                            else
                            begin
                                fill1_next = fill1_reg + FILL_W'(1);
                            end
                        end
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        launch.vld  = 1'b1;
                        launch.head = req.head_track;
                        launch.bank = active_reg;
                        // An empty active queue takes over the add queue.
                        if (act_cnt_reg == '0 && fill_add != '0)
                        begin
                            active_next  = ~active_reg;
                            act_cnt_next = fill_add;
                            launch.bank  = ~active_reg;
                            if (active_reg)
                            begin
                                fill1_next = '0;
                            end
                            else
                            begin
                                fill0_next = '0;
                            end
                        end
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tok_last.vld)
                begin
                    pend_dropped_next = 1'b0;
                    pend_granted_next = 1'b0;
                    pend_id_next      = '0;
                    pend_track_next   = '0;
                    if (act_cnt_reg != '0)
                    begin
                        pend_granted_next = 1'b1;
                        clr.en            = 1'b1;
                        clr.bank          = tok_last.bank;
                        act_cnt_next      = act_cnt_reg - FILL_W'(1);
                        if (tok_last.ex_hit)
                        begin
                            pend_id_next    = tok_last.ex_id;
                            pend_track_next = tok_last.head;
                            clr.idx         = tok_last.ex_idx;
                        end
                        else if ((moving_up_reg && tok_last.up_hit) ||
                                 (!moving_up_reg && !tok_last.dn_hit))
                        begin
                            // Upward pick, either ahead or after reversing from down.
                            moving_up_next  = 1'b1;
                            pend_id_next    = tok_last.up_id;
                            pend_track_next = tok_last.up_track;
                            clr.idx         = tok_last.up_idx;
                        end
                        else
                        begin
                            moving_up_next  = 1'b0;
                            pend_id_next    = tok_last.dn_id;
                            pend_track_next = tok_last.dn_track;
                            clr.idx         = tok_last.dn_idx;
                        end
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_vld_reg || res.ready)
                begin
                    out_vld_next     = 1'b1;
                    out_granted_next = pend_granted_reg;
                    out_id_next      = pend_id_reg;
                    out_track_next   = pend_track_reg;
                    out_dropped_next = pend_dropped_reg;
                    out_empty_next   = (act_cnt_reg == '0) && (fill_add == '0);
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            moving_up_reg <= 1'b1;
            fill0_reg     <= '0;
            fill1_reg     <= '0;
            act_cnt_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            moving_up_reg <= moving_up_next;
            fill0_reg     <= fill0_next;
            fill1_reg     <= fill1_next;
            act_cnt_reg   <= act_cnt_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_granted_reg <= pend_granted_next;
        pend_id_reg      <= pend_id_next;
        pend_track_reg   <= pend_track_next;
        pend_dropped_reg <= pend_dropped_next;
        out_granted_reg  <= out_granted_next;
        out_id_reg       <= out_id_next;
        out_track_reg    <= out_track_next;
        out_dropped_reg  <= out_dropped_next;
        out_empty_reg    <= out_empty_next;
    end

    assign res.valid       = out_vld_reg;
    assign res.granted     = out_granted_reg;
    assign res.grant_id    = out_id_reg;
    assign res.grant_track = out_track_reg;
    assign res.dropped     = out_dropped_reg;
    assign res.all_empty   = out_empty_reg;

endmodule

[rtl/core/fdrs_cell.sv]
`timescale 1ns / 1ps
// One request cell: holds slot CELL_IDX of both banks and refines the search
// token as it passes by. Depends on fdrs_pkg.
module fdrs_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fdrs_pkg::wr_cmd_t  wr,
    input  fdrs_pkg::clr_cmd_t clr,
    input  fdrs_pkg::token_t   tok_in,
    output fdrs_pkg::token_t   tok_out
);
    import fdrs_pkg::*;

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

    logic [TRACK_W-1:0] track_reg [2];
    logic [ID_W-1:0]    id_reg [2];
    logic [1:0]         valid_reg;
    logic [1:0]         valid_next;
    token_t             tok_reg;
    token_t             tok_next;
    logic               cur_v;
    logic [TRACK_W-1:0] cur_t;
    logic [ID_W-1:0]    cur_id;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == MY_IDX)
        begin
            track_reg[wr.bank] <= wr.track;
            id_reg[wr.bank]    <= wr.id;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en && wr.idx == MY_IDX)
        begin
            valid_next[wr.bank] = 1'b1;
        end
        if (clr.en && clr.idx == MY_IDX)
        begin
            valid_next[clr.bank] = 1'b0;
        end
    end

    // Strict compares keep the earlier (older) slot on ties.
    always_comb
    begin
        cur_v    = valid_reg[tok_in.bank];
        cur_t    = track_reg[tok_in.bank];
        cur_id   = id_reg[tok_in.bank];
        tok_next = tok_in;
        if (tok_in.vld && cur_v)
        begin
            if (!tok_in.ex_hit && cur_t == tok_in.head)
            begin
                tok_next.ex_hit = 1'b1;
                tok_next.ex_idx = MY_IDX;
                tok_next.ex_id  = cur_id;
            end
            if (cur_t > tok_in.head && (!tok_in.up_hit || cur_t < tok_in.up_track))
            begin
                tok_next.up_hit   = 1'b1;
                tok_next.up_idx   = MY_IDX;
                tok_next.up_id    = cur_id;
                tok_next.up_track = cur_t;
            end
            if (cur_t < tok_in.head && (!tok_in.dn_hit || cur_t > tok_in.dn_track))
            begin
                tok_next.dn_hit   = 1'b1;
                tok_next.dn_idx   = MY_IDX;
                tok_next.dn_id    = cur_id;
                tok_next.dn_track = cur_t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/core/fdrs_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the result channel of the disk request scheduler, and the
// bind that attaches them to the top level. Depends on fdrs_pkg.
module fdrs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        granted,
    input logic [fdrs_pkg::ID_W-1:0]    grant_id,
    input logic [fdrs_pkg::TRACK_W-1:0] grant_track,
    input logic                        dropped,
    input logic                        all_empty
);
    import fdrs_pkg::*;

    // A stalled result item keeps its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(granted) &&
        $stable(grant_id) && $stable(grant_track) && $stable(dropped) &&
        $stable(all_empty))
        else $error("result item changed while stalled");

    // An item is either an add or a grant, never both outcomes.
    a_grant_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(granted && dropped))
        else $error("granted and dropped both set");

    // A drop means the add queue is full, so the queues cannot be empty.
    a_drop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && dropped |-> !all_empty)
        else $error("dropped item reports empty queues");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !granted |-> grant_id == '0 && grant_track == '0)
        else $error("grant fields not zero without a grant");

endmodule

bind flook_disk_request_scheduler fdrs_checker u_fdrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .granted     (res.granted),
    .grant_id    (res.grant_id),
    .grant_track (res.grant_track),
    .dropped     (res.dropped),
    .all_empty   (res.all_empty)
);

[tb/sv/fdrs_grant_checker.sv]
`timescale 1ns / 1ps
// Checker for the disk request scheduler: watches the request and result channels,
// predicts each grant from its own copy of both queues, and compares field by field.
// Depends on fdrs_pkg and on the fdrs_req_if / fdrs_res_if interfaces.
module fdrs_grant_checker #(
    parameter int DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    fdrs_req_if        req,
    fdrs_res_if        res,
    output int         fail_count,
    output int         pending_count,
    output int         grant_count,
    output int         drop_count,
    output int         reversal_count
);
    import fdrs_pkg::*;

    typedef struct packed {
        logic               granted;
        logic [ID_W-1:0]    id;
        logic [TRACK_W-1:0] track;
        logic               dropped;
        logic               all_empty;
    } grant_result_t;

    // Two banks of DEPTH slots; cur_bank is the one being served.
    logic [TRACK_W-1:0] slot_track [2*DEPTH];
    logic [ID_W-1:0]    slot_id    [2*DEPTH];
    bit                 slot_busy  [2*DEPTH];
    int                 bank_count [2];
    bit                 cur_bank;
    bit                 sweep_up;

    grant_result_t expected_grants [$];

    function automatic bit bank_idle(input bit b);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_busy[b*DEPTH + i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Nearest busy slot strictly on one side of the head; the oldest wins a tie.
    function automatic int closest(input bit b, input logic [TRACK_W-1:0] head, input bit up);
        int pick;
        int best;
        int delta;
        int s;
        pick = -1;
        best = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            s = b*DEPTH + i;
            if (!slot_busy[s])
                continue;
            if (up && slot_track[s] > head)
                delta = int'(slot_track[s]) - int'(head);
            else if (!up && slot_track[s] < head)
                delta = int'(head) - int'(slot_track[s]);
            else
                continue;
            if (pick < 0 || delta < best)
            begin
                best = delta;
                pick = s;
            end
        end
        return pick;
    endfunction

    function automatic grant_result_t next_grant(input logic cmd,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [TRACK_W-1:0] trk,
                                                 input logic [TRACK_W-1:0] head);
        grant_result_t r;
        bit            add_bank;
        int            s;
        int            pick;
        r        = '0;
        add_bank = !cur_bank;
        if (cmd == CMD_ADD)
        begin
            if (bank_count[add_bank] >= DEPTH)
            begin
                r.dropped = 1'b1;
            end
            else
            begin
                s = add_bank*DEPTH + bank_count[add_bank];
                slot_id[s]    = id;
                slot_track[s] = trk;
                slot_busy[s]  = 1'b1;
                bank_count[add_bank]++;
            end
        end
        else
        begin
            // An empty active queue hands over to the add queue before the search.
            if (bank_idle(cur_bank) && bank_count[add_bank] != 0)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    slot_busy[cur_bank*DEPTH + i] = 1'b0;
                end
                bank_count[cur_bank] = 0;
                cur_bank = add_bank;
            end
            if (!bank_idle(cur_bank))
            begin
                pick = -1;
                for (int i = 0; i < DEPTH; i++)
                begin
                    s = cur_bank*DEPTH + i;
                    if (pick < 0 && slot_busy[s] && slot_track[s] == head)
                        pick = s;
                end
                if (pick < 0)
                    pick = closest(cur_bank, head, sweep_up);
                if (pick < 0)
                begin
                    sweep_up = !sweep_up;
                    reversal_count++;
                    pick = closest(cur_bank, head, sweep_up);
                end
                r.granted       = 1'b1;
                r.id            = slot_id[pick];
                r.track         = slot_track[pick];
                slot_busy[pick] = 1'b0;
            end
        end
        r.all_empty = bank_idle(cur_bank) && bank_count[!cur_bank] == 0;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        grant_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 2*DEPTH; i++)
            begin
                slot_busy[i] = 1'b0;
            end
            bank_count[0]  = 0;
            bank_count[1]  = 0;
            cur_bank       = 1'b0;
            sweep_up       = 1'b1;
            fail_count     = 0;
            pending_count  = 0;
            grant_count    = 0;
            drop_count     = 0;
            reversal_count = 0;
            expected_grants.delete();
        end
        else
        begin
            // Results are retired before the new command is predicted, so a result
            // can never be matched against an item accepted on the same edge.
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("result item arrived with no command waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    check_field("granted", want.granted, res.granted);
                    check_field("grant_id", want.id, res.grant_id);
                    check_field("grant_track", want.track, res.grant_track);
                    check_field("dropped", want.dropped, res.dropped);
                    check_field("all_empty", want.all_empty, res.all_empty);
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                want = next_grant(req.command, req.request_id, req.request_track,
                                  req.head_track);
                if (want.granted)
                    grant_count++;
                if (want.dropped)
                    drop_count++;
                expected_grants = {expected_grants, want};
            end
            pending_count = expected_grants.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the disk request scheduler testbench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on fdrs_pkg, the channel
// interfaces, flook_disk_request_scheduler and fdrs_grant_checker.
module testbench;
    import fdrs_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 850;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending_count;
    int grant_count;
    int drop_count;
    int reversal_count;

    int commands_sent;
    int recent_tracks [$];
    int track_base;
    bit quiet;

    fdrs_req_if req_ch ();
    fdrs_res_if res_ch ();

    flook_disk_request_scheduler #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .res  (res_ch)
    );

    fdrs_grant_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .res           (res_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .grant_count   (grant_count),
        .drop_count    (drop_count),
        .reversal_count(reversal_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Tracks cluster around a per-phase base so that ties and exact hits are common.
    function automatic int pick_track();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 4095;
        if (r < 6)
            return track_base + $urandom_range(0, 7);
        return $urandom_range(0, 4095);
    endfunction

    function automatic int pick_head();
        if (recent_tracks.size() != 0 && $urandom_range(0, 2) == 0)
            return recent_tracks[$urandom_range(0, recent_tracks.size() - 1)];
        return pick_track();
    endfunction

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic issue(input logic cmd, input int id, input int trk, input int head);
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.command       <= cmd;
        req_ch.request_id    <= id[ID_W-1:0];
        req_ch.request_track <= trk[TRACK_W-1:0];
        req_ch.head_track    <= head[TRACK_W-1:0];
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        commands_sent++;
        if (cmd == CMD_ADD)
        begin
            recent_tracks = {recent_tracks, trk};
            if (recent_tracks.size() > 64)
                void'(recent_tracks.pop_front());
        end
        hold_off(next_gap());
    endtask

    // The fields a command ignores still carry random values.
    task automatic add_req(input int id, input int trk);
        issue(CMD_ADD, id, trk, $urandom_range(0, 4095));
    endtask

    task automatic grant_req(input int head);
        issue(CMD_GRANT, $urandom_range(0, 1023), $urandom_range(0, 4095), head);
    endtask

    // Result side: runs of ready, short stalls, now and then a long stall or a
    // long stretch with no stalls at all.
    initial
    begin
        int ready_len;
        int stall_len;
        res_ch.ready = 1'b0;
        forever
        begin
            ready_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
            stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
            @(negedge clk);
            res_ch.ready <= 1'b1;
            repeat (ready_len - 1) @(negedge clk);
            @(negedge clk);
            res_ch.ready <= 1'b0;
            repeat (stall_len - 1) @(negedge clk);
        end
    end

    initial
    begin
        int phase;
        int kind;
        int n_add;
        int n_grant;
        int n_mix;
        int directed_count;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_ADD;
        req_ch.request_id    = '0;
        req_ch.request_track = '0;
        req_ch.head_track    = '0;
        commands_sent        = 0;
        track_base           = 2040;
        quiet                = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty grant, field extremes, exact hits with a tie, the
        // nearest request upward, a reversal downward, and a swap into a new queue.
        grant_req(0);
        add_req(0, 0);
        add_req(1023, 4095);
        add_req(5, 2048);
        add_req(6, 2048);
        add_req(7, 2050);
        add_req(8, 2046);
        add_req(9, 2052);
        add_req(10, 2052);
        grant_req(2048);
        grant_req(2048);
        grant_req(2048);
        grant_req(2051);
        grant_req(2051);
        grant_req(4095);
        add_req(11, 100);
        grant_req(4095);
        grant_req(4095);
        grant_req(0);
        grant_req(4095);
        directed_count = commands_sent;

        phase = 0;
        while (commands_sent < directed_count + RANDOM_ITEMS)
        begin
            phase++;
            quiet      = ($urandom_range(0, 4) == 0);
            track_base = $urandom_range(0, 4095 - 7);
            kind       = $urandom_range(0, 9);
            if (phase % 25 == 3)
            begin
                hold_off(1);
                wait (pending_count == 0);
            end
            if (kind < 6)
            begin
                // Well-formed: a batch of requests, then grants to serve them.
                n_add   = $urandom_range(1, 36);
                n_grant = $urandom_range(1, n_add + 3);
                repeat (n_add) add_req($urandom_range(0, 1023), pick_track());
                repeat (n_grant) grant_req(pick_head());
            end
            else if (kind < 8)
            begin
                n_mix = $urandom_range(10, 30);
                repeat (n_mix)
                begin
                    if ($urandom_range(0, 1) == 0)
                        add_req($urandom_range(0, 1023), pick_track());
                    else
                        grant_req(pick_head());
                end
            end
            else if (kind == 8)
            begin
                // Overfill the add queue.
                n_add = $urandom_range(34, 40);
                repeat (n_add) add_req($urandom_range(0, 1023), pick_track());
            end
            else
            begin
                n_grant = $urandom_range(3, 10);
                repeat (n_grant) grant_req(pick_head());
            end
        end

        hold_off(1);
        wait (pending_count == 0);
        repeat (50) @(posedge clk);

        $display("Run covered %0d commands: %0d requests granted, %0d adds dropped,",
                 commands_sent, grant_count, drop_count);
        $display("%0d direction reversals, with random gaps and stalls on both channels.",
                 reversal_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
rtl/core/fdrs_pkg.sv
rtl/core/fdrs_req_if.sv
rtl/core/fdrs_res_if.sv
rtl/core/fdrs_cell.sv
rtl/core/flook_disk_request_scheduler.sv
rtl/core/fdrs_checker.sv
tb/sv/fdrs_grant_checker.sv
tb/sv/testbench.sv
